// ===== rtl/sdpr_pkg.sv =====
package sdpr_pkg;

  // Encoder counter and error width
  localparam int COUNT_BITS = 32;

  // Fixed field widths
  localparam int TIME_BITS  = 32;
  localparam int DRIVE_BITS = 9;
  localparam int EDGE_BITS  = 8;
  localparam int GAIN_BITS  = 12;
  localparam int STEP_BITS  = 8;

  // Correction arithmetic: gains carry 8 fraction bits, result saturates to 16 bits
  localparam int FRAC_BITS  = 8;
  localparam int CORR_BITS  = 16;
  localparam int QUO_BITS   = CORR_BITS - 1;
  localparam int SUM_BITS   = CORR_BITS + 2;
  localparam int QCNT_BITS  = $clog2(QUO_BITS);

  // Shared multiply-accumulate unit: one 8-bit digit of the multiplier per cycle
  localparam int DIGIT_BITS   = 8;
  localparam int PROD_BITS    = COUNT_BITS + GAIN_BITS + TIME_BITS;
  localparam int MPLIER_BITS  = TIME_BITS;
  localparam int MS_SCALE     = 1000;
  localparam int SCALE_BITS   = 10;
  localparam int GAIN_DIGITS  = (GAIN_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int TIME_DIGITS  = (TIME_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int SCALE_DIGITS = (SCALE_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int MCNT_BITS    = $clog2(TIME_DIGITS + 1);

  // Configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = GAIN_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_DEADBAND    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RISE_STEP   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FALL_STEP   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_KP_GAIN     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_KD_GAIN     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_DRIVE_LIMIT = 3'd5;

  localparam logic [STEP_BITS-1:0] DEADBAND_RESET    = 8'd15;
  localparam logic [STEP_BITS-1:0] RISE_STEP_RESET   = 8'd3;
  localparam logic [STEP_BITS-1:0] FALL_STEP_RESET   = 8'd5;
  localparam logic [GAIN_BITS-1:0] KP_GAIN_RESET     = 12'd128;
  localparam logic [GAIN_BITS-1:0] KD_GAIN_RESET     = 12'd384;
  localparam logic [STEP_BITS-1:0] DRIVE_LIMIT_RESET = 8'd128;

  localparam logic signed [CORR_BITS-1:0] CORR_MAX = 16'sh7fff;
  localparam logic signed [CORR_BITS-1:0] CORR_MIN = 16'sh8000;

endpackage

// ===== rtl/straight_drive_pd_ramp_top.sv =====
// Straight-line drive controller for a two-wheel base. Each accepted item is one control
// tick; it yields exactly one result item. Ticks that stop the base or are not straight go
// from the evaluate state to the result register; the next tick can be taken once the
// block is back in idle. After setup, a straight tick's PD term runs on one shared adder,
// first as a radix-256 multiplier (ten digit steps for kp*|err|*ms and kd*|derr|*1000),
// then for the sign merge (a second merge step when the P and D products have opposite
// signs and the D product is the larger) and saturation test, then as a restoring divider
// that retires one of the 15 quotient bits per cycle. A saturating correction skips the
// divider. A stalled result holds the tick in the finish state until the output register
// is free. cmd_stall stays high while a tick is in work; a finished result waits in the
// output register, so the next tick may be accepted before the last result is taken.
module straight_drive_pd_ramp_top (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [sdpr_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [sdpr_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                                    cmd_valid,
  output logic                                    cmd_stall,
  input  logic signed [sdpr_pkg::DRIVE_BITS-1:0]  req_left,
  input  logic signed [sdpr_pkg::DRIVE_BITS-1:0]  req_right,
  input  logic [sdpr_pkg::EDGE_BITS-1:0]          edges_left,
  input  logic [sdpr_pkg::EDGE_BITS-1:0]          edges_right,
  input  logic [sdpr_pkg::TIME_BITS-1:0]          time_ms,
  output logic                                    res_valid,
  input  logic                                    res_stall,
  output logic signed [sdpr_pkg::DRIVE_BITS-1:0]  drive_left,
  output logic signed [sdpr_pkg::DRIVE_BITS-1:0]  drive_right,
  output logic                                    stopped,
  output logic                                    straight
);
  import sdpr_pkg::*;

  localparam int PW = PROD_BITS;
  localparam int CB = COUNT_BITS;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EVAL, ST_SETUP, ST_MUL, ST_COMB, ST_COMB2, ST_SAT, ST_DIV, ST_FINISH
  } state_t;

  typedef enum logic [1:0] {MOP_KP, MOP_MS, MOP_KD, MOP_SCALE} mul_op_t;

  state_t  state;
  mul_op_t mop;

  // Configuration
  logic [STEP_BITS-1:0] deadband, rise_step, fall_step, drive_limit;
  logic [GAIN_BITS-1:0] kp_gain, kd_gain;

  // Controller state
  logic signed [DRIVE_BITS-1:0] ramp_left, ramp_right;
  logic                         last_left_fwd, last_right_fwd, was_straight;
  logic [CB-1:0]                count_left, count_right, prev_error;
  logic [TIME_BITS-1:0]         prev_time;

  // Item registers
  logic signed [DRIVE_BITS-1:0] dl, dr, tl, tr;
  logic [EDGE_BITS-1:0]         el, er;
  logic [TIME_BITS-1:0]         tnow, ms;
  logic                         item_stop, is_straight, item_bwd, item_turn;
  logic                         pn, dn, mag_neg;
  logic [CB-1:0]                da;

  // Shared unit registers
  logic [PW-1:0]          acc, mcand, preg, ds;
  logic [MPLIER_BITS-1:0] mplier;
  logic [MCNT_BITS-1:0]   mcnt;
  logic [QUO_BITS-1:0]    q;
  logic [QCNT_BITS-1:0]   qcnt;
  logic signed [CORR_BITS-1:0] corr;

  // Clamp a corrected drive to the symmetric limit
  function automatic logic signed [DRIVE_BITS-1:0] clamp_drive(
    input logic signed [SUM_BITS-1:0] v,
    input logic [STEP_BITS-1:0]       lim
  );
    logic signed [SUM_BITS-1:0] lim_s;
    lim_s = $signed({{(SUM_BITS-STEP_BITS){1'b0}}, lim});
    if (v > lim_s) begin
      return lim_s[DRIVE_BITS-1:0];
    end else if (v < -lim_s) begin
      return DRIVE_BITS'(-lim_s);
    end
    return v[DRIVE_BITS-1:0];
  endfunction

  // Move the ramp toward its target by at most one step
  function automatic logic signed [DRIVE_BITS-1:0] ramp_to(
    input logic signed [DRIVE_BITS-1:0] cur,
    input logic signed [DRIVE_BITS-1:0] tgt,
    input logic [STEP_BITS-1:0]         up,
    input logic [STEP_BITS-1:0]         down
  );
    logic signed [DRIVE_BITS+1:0] cw, tw, nw;
    cw = $signed({{2{cur[DRIVE_BITS-1]}}, cur});
    tw = $signed({{2{tgt[DRIVE_BITS-1]}}, tgt});
    nw = cw;
    if (cw < tw) begin
      nw = cw + $signed({{(DRIVE_BITS+2-STEP_BITS){1'b0}}, up});
      if (nw > tw) nw = tw;
    end else if (cw > tw) begin
      nw = cw - $signed({{(DRIVE_BITS+2-STEP_BITS){1'b0}}, down});
      if (nw < tw) nw = tw;
    end
    return nw[DRIVE_BITS-1:0];
  endfunction

  // Deadband and direction flags of the latched demands
  logic [DRIVE_BITS-1:0]        abs_l, abs_r;
  logic signed [DRIVE_BITS-1:0] tl_db, tr_db;
  logic l_pos, r_pos, l_neg, r_neg;
  logic e_bwd, e_straight, e_turn, e_stop;
  logic [CB-1:0] cl_sum, cr_sum;

  always_comb begin
    abs_l = dl[DRIVE_BITS-1] ? DRIVE_BITS'(-dl) : dl;
    abs_r = dr[DRIVE_BITS-1] ? DRIVE_BITS'(-dr) : dr;
    tl_db = (abs_l < {1'b0, deadband}) ? '0 : dl;
    tr_db = (abs_r < {1'b0, deadband}) ? '0 : dr;
    l_neg = tl_db[DRIVE_BITS-1];
    r_neg = tr_db[DRIVE_BITS-1];
    l_pos = !l_neg && (tl_db != '0);
    r_pos = !r_neg && (tr_db != '0);
    e_bwd = l_neg && r_neg;
    e_straight = (l_pos && r_pos) || e_bwd;
    e_turn = (l_pos && r_neg) || (l_neg && r_pos);
    e_stop = ((tl_db == '0) && (tr_db == '0)) ||
             (last_left_fwd != l_pos) || (last_right_fwd != r_pos);
    cl_sum = count_left + CB'(el);
    cr_sum = count_right + CB'(er);
  end

  // Error, error change and elapsed time
  logic [CB-1:0]        err, ea;
  logic [CB:0]          diff, da_full;
  logic [TIME_BITS-1:0] ms_raw, ms_v;

  always_comb begin
    err     = count_left - count_right;
    diff    = {err[CB-1], err} - {prev_error[CB-1], prev_error};
    ea      = err[CB-1] ? -err : err;
    da_full = diff[CB] ? -diff : diff;
    ms_raw  = tnow - prev_time;
    ms_v    = (ms_raw == '0) ? TIME_BITS'(1) : ms_raw;
  end

  // Shared unit: digit multiplier feeding one wide add/subtract
  logic [PW+DIGIT_BITS-1:0] pprod;
  logic [PW-1:0]            add_a, add_b, sat_lim, ds_init;
  logic                     add_sub, add_carry;
  logic [PW:0]              add_sum;
  logic [QUO_BITS-1:0]      q_next;

  assign pprod = {{DIGIT_BITS{1'b0}}, mcand} * {{PW{1'b0}}, mplier[DIGIT_BITS-1:0]};
  assign sat_lim = {{(PW-TIME_BITS){1'b0}}, ms} << (FRAC_BITS + QUO_BITS);
  assign ds_init = {{(PW-TIME_BITS){1'b0}}, ms} << (FRAC_BITS + QUO_BITS - 1);

  always_comb begin
    add_a   = acc;
    add_b   = '0;
    add_sub = 1'b0;
    case (state)
      ST_MUL: begin
        add_b = pprod[PW-1:0];
      end
      ST_COMB: begin
        add_a   = preg;
        add_b   = acc;
        add_sub = pn ^ dn;
      end
      ST_COMB2: begin
        add_a   = acc;
        add_b   = preg;
        add_sub = 1'b1;
      end
      ST_SAT: begin
        add_b   = sat_lim;
        add_sub = 1'b1;
      end
      ST_DIV: begin
        add_b   = ds;
        add_sub = 1'b1;
      end
      default: begin
        add_b = '0;
      end
    endcase
    add_sum   = {1'b0, add_a} + {1'b0, add_b ^ {PW{add_sub}}} + {{PW{1'b0}}, add_sub};
    add_carry = add_sum[PW];
    q_next    = {q[QUO_BITS-2:0], add_carry};
  end

  // Apply correction, clamp and ramp (turns skip the ramp)
  logic signed [SUM_BITS-1:0]   tl_w, tr_w, c_w, vl, vr;
  logic signed [DRIVE_BITS-1:0] cl_l, cl_r, nr_l, nr_r;
  logic                         out_free;

  always_comb begin
    tl_w = $signed({{(SUM_BITS-DRIVE_BITS){tl[DRIVE_BITS-1]}}, tl});
    tr_w = $signed({{(SUM_BITS-DRIVE_BITS){tr[DRIVE_BITS-1]}}, tr});
    c_w  = $signed({{(SUM_BITS-CORR_BITS){corr[CORR_BITS-1]}}, corr});
    vl   = item_bwd ? tl_w + c_w : tl_w - c_w;
    vr   = item_bwd ? tr_w - c_w : tr_w + c_w;
    cl_l = clamp_drive(vl, drive_limit);
    cl_r = clamp_drive(vr, drive_limit);
    nr_l = item_turn ? cl_l : ramp_to(ramp_left, cl_l, rise_step, fall_step);
    nr_r = item_turn ? cl_r : ramp_to(ramp_right, cl_r, rise_step, fall_step);
  end

  assign out_free  = !res_valid || !res_stall;
  assign cmd_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      mop            <= MOP_KP;
      res_valid      <= 1'b0;
      deadband       <= DEADBAND_RESET;
      rise_step      <= RISE_STEP_RESET;
      fall_step      <= FALL_STEP_RESET;
      kp_gain        <= KP_GAIN_RESET;
      kd_gain        <= KD_GAIN_RESET;
      drive_limit    <= DRIVE_LIMIT_RESET;
      ramp_left      <= '0;
      ramp_right     <= '0;
      last_left_fwd  <= 1'b0;
      last_right_fwd <= 1'b0;
      was_straight   <= 1'b0;
      count_left     <= '0;
      count_right    <= '0;
      prev_error     <= '0;
      prev_time      <= '0;
    end else begin
      // Take configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DEADBAND:    deadband    <= cfg_data[STEP_BITS-1:0];
          REG_RISE_STEP:   rise_step   <= cfg_data[STEP_BITS-1:0];
          REG_FALL_STEP:   fall_step   <= cfg_data[STEP_BITS-1:0];
          REG_KP_GAIN:     kp_gain     <= cfg_data;
          REG_KD_GAIN:     kd_gain     <= cfg_data;
          REG_DRIVE_LIMIT: drive_limit <= cfg_data[STEP_BITS-1:0];
          default: ;
        endcase
      end

      // Drop the result once taken
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            dl    <= req_left;
            dr    <= req_right;
            el    <= edges_left;
            er    <= edges_right;
            tnow  <= time_ms;
            state <= ST_EVAL;
          end
        end

        ST_EVAL: begin
          // Count edges, remember direction, pick the path
          last_left_fwd  <= l_pos;
          last_right_fwd <= r_pos;
          tl             <= tl_db;
          tr             <= tr_db;
          item_stop      <= e_stop;
          is_straight    <= e_straight;
          item_bwd       <= e_bwd;
          item_turn      <= e_turn;
          corr           <= '0;
          count_left     <= cl_sum;
          count_right    <= cr_sum;
          if (e_stop) begin
            state <= ST_FINISH;
          end else begin
            was_straight <= e_straight;
            if (e_straight && !was_straight) begin
              count_left  <= '0;
              count_right <= '0;
              prev_error  <= '0;
              prev_time   <= tnow;
            end
            state <= e_straight ? ST_SETUP : ST_FINISH;
          end
        end

        ST_SETUP: begin
          // Latch error terms and start kp * |err|
          ms         <= ms_v;
          pn         <= err[CB-1];
          dn         <= diff[CB];
          da         <= da_full[CB-1:0];
          prev_error <= err;
          prev_time  <= tnow;
          acc        <= '0;
          mcand      <= {{(PW-CB){1'b0}}, ea};
          mplier     <= {{(MPLIER_BITS-GAIN_BITS){1'b0}}, kp_gain};
          mcnt       <= MCNT_BITS'(GAIN_DIGITS);
          mop        <= MOP_KP;
          state      <= ST_MUL;
        end

        ST_MUL: begin
          // Accumulate one multiplier digit
          acc    <= add_sum[PW-1:0];
          mcand  <= mcand << DIGIT_BITS;
          mplier <= mplier >> DIGIT_BITS;
          mcnt   <= mcnt - MCNT_BITS'(1);
          if (mcnt == MCNT_BITS'(1)) begin
            acc <= '0;
            unique case (mop)
              MOP_KP: begin
                mcand  <= add_sum[PW-1:0];
                mplier <= ms;
                mcnt   <= MCNT_BITS'(TIME_DIGITS);
                mop    <= MOP_MS;
              end
              MOP_MS: begin
                preg   <= add_sum[PW-1:0];
                mcand  <= {{(PW-CB){1'b0}}, da};
                mplier <= {{(MPLIER_BITS-GAIN_BITS){1'b0}}, kd_gain};
                mcnt   <= MCNT_BITS'(GAIN_DIGITS);
                mop    <= MOP_KD;
              end
              MOP_KD: begin
                mcand  <= add_sum[PW-1:0];
                mplier <= MPLIER_BITS'(MS_SCALE);
                mcnt   <= MCNT_BITS'(SCALE_DIGITS);
                mop    <= MOP_SCALE;
              end
              MOP_SCALE: begin
                acc   <= add_sum[PW-1:0];
                state <= ST_COMB;
              end
            endcase
          end
        end

        ST_COMB: begin
          // Merge the signed P and D products into a magnitude
          if (!(pn ^ dn) || add_carry) begin
            acc     <= add_sum[PW-1:0];
            mag_neg <= pn;
            state   <= ST_SAT;
          end else begin
            mag_neg <= dn;
            state   <= ST_COMB2;
          end
        end

        ST_COMB2: begin
          acc   <= add_sum[PW-1:0];
          state <= ST_SAT;
        end

        ST_SAT: begin
          // Saturate when the quotient reaches 2^15
          if (add_carry) begin
            corr  <= mag_neg ? CORR_MIN : CORR_MAX;
            state <= ST_FINISH;
          end else begin
            ds    <= ds_init;
            q     <= '0;
            qcnt  <= QCNT_BITS'(QUO_BITS - 1);
            state <= ST_DIV;
          end
        end

        ST_DIV: begin
          // Retire one quotient bit
          if (add_carry) begin
            acc <= add_sum[PW-1:0];
          end
          q    <= q_next;
          ds   <= ds >> 1;
          qcnt <= qcnt - QCNT_BITS'(1);
          if (qcnt == '0) begin
            corr  <= mag_neg ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
            state <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          // Hold until the output register is free
          if (out_free) begin
            res_valid <= 1'b1;
            if (item_stop) begin
              ramp_left   <= '0;
              ramp_right  <= '0;
              drive_left  <= '0;
              drive_right <= '0;
              stopped     <= 1'b1;
              straight    <= 1'b0;
            end else begin
              ramp_left   <= nr_l;
              ramp_right  <= nr_r;
              drive_left  <= nr_l;
              drive_right <= nr_r;
              stopped     <= 1'b0;
              straight    <= is_straight;
            end
            state <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
